FILE: src/gle_pkg.sv
package gle_pkg;

  // Fixed field widths
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 16;
  localparam int unsigned SCNT_W  = 7;
  localparam int unsigned UPEM_W  = 15;
  localparam int unsigned PSZ_W   = 11;
  localparam int unsigned OP_W    = 17;              // scale operand, signed
  localparam int unsigned PROD_W  = OP_W + PSZ_W + 1; // signed product
  localparam int unsigned MAG_W   = PROD_W - 1;      // product magnitude
  localparam int unsigned KCNT_W  = 3;
  localparam int unsigned NSCALE  = 6;

  // Reset values of the configuration registers
  localparam logic [SCNT_W-1:0] RST_SEG_CNT  = 7'd0;
  localparam logic [UPEM_W-1:0] RST_UPEM     = 15'd2048;
  localparam logic [PSZ_W-1:0]  RST_PIX_SIZE = 11'd64;
  localparam logic [15:0]       RST_START_X  = 16'd10;
  localparam logic [15:0]       RST_BASE_Y   = 16'd70;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_SEG   = 3'd0,
    MODE_LOAD_GLYPH = 3'd1,
    MODE_LOAD_EMPTY = 3'd2,
    MODE_DRAW       = 3'd3,
    MODE_RESTART    = 3'd4
  } gle_mode_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_SEG_CNT  = 3'd0,
    REG_UPEM     = 3'd1,
    REG_PIX_SIZE = 3'd2,
    REG_START_X  = 3'd3,
    REG_BASE_Y   = 3'd4
  } gle_reg_e;

  // Scale operand order, also the result slot
  typedef enum logic [KCNT_W-1:0] {
    SC_LSB  = 3'd0,
    SC_XMIN = 3'd1,
    SC_YMAX = 3'd2,
    SC_W    = 3'd3,
    SC_H    = 3'd4,
    SC_ADV  = 3'd5
  } gle_scale_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEG_RD,
    ST_SEG_CMP,
    ST_MET_RD,
    ST_BOX_RD,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_FIN
  } gle_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SLOT_W-1:0]       slot;
    logic [CODE_W-1:0]       code;
    logic [CODE_W-1:0]       code_last;
    logic [CODE_W-1:0]       code_delta;
    logic signed [15:0]      box_x_min;
    logic signed [15:0]      box_y_min;
    logic signed [15:0]      box_x_max;
    logic signed [15:0]      box_y_max;
    logic [15:0]             advance;
    logic signed [15:0]      bearing;
  } gle_in_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic [SLOT_W-1:0]  glyph_number;
  } gle_out_t;

  typedef struct packed {
    logic [CIDX_W-1:0] index;
    logic [CDAT_W-1:0] data;
  } gle_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
    logic [CODE_W-1:0] delta;
  } gle_seg_t;

  typedef struct packed {
    logic [15:0] xmin;
    logic [15:0] ymin;
    logic [15:0] xmax;
    logic [15:0] ymax;
  } gle_box_t;

  typedef struct packed {
    logic        outlined;
    logic [15:0] adv;
    logic [15:0] lsb;
  } gle_met_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic draw_go;
    logic seg_rd;
    logic seg_chk;
    logic met_rd;
    logic box_rd;
    logic mul;
    logic div_go;
    logic res_store;
    logic out_load;
  } gle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_draw;
    logic seg_end;
    logic seg_hit;
    logic last_scale;
    logic div_busy;
    logic out_free;
  } gle_sts_t;

endpackage

FILE: src/gle_if.sv
interface gle_in_if;
  logic            valid;
  logic            ready;
  gle_pkg::gle_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gle_out_if;
  logic             valid;
  logic             ready;
  gle_pkg::gle_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gle_cfg_if;
  logic             valid;
  logic             ready;
  gle_pkg::gle_cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/glyph_layout_engine_unit.sv
// Glyph layout engine: character map lookup plus scaled glyph placement.
// item_i   words carry a mode: load segment, load glyph (with or without
//          outline), draw a character, or restart the cursor.
// result_o gives one rectangle word per draw; other modes give nothing.
// cfg_i    writes segment count, units per em, pixel size, start column and
//          baseline; always ready, use only while the block is idle.
// Loads and restart are done from the idle state. A draw walks the segment
// table, a registered read and then a compare for each segment, reads metrics
// and then the box, then scales six values through one multiplier and a
// shared radix-2 divider, one value after another.
// The input is taken only between items. A finished rectangle sits in the
// output register; the next item is still taken while it waits, and a draw
// stalls at its end until that register frees up.
// Reset loads the register defaults and sets the cursor to the start
// column; the tables hold nothing valid until loaded.
module glyph_layout_engine_unit #(
  parameter int unsigned SEGMENTS = 64,
  parameter int unsigned GLYPHS   = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gle_in_if.sink    item_i,
  gle_out_if.source result_o,
  gle_cfg_if.sink   cfg_i
);
  import gle_pkg::*;

  gle_cmd_t cmd;
  gle_sts_t sts;

  // registers are always writable
  assign cfg_i.ready = 1'b1;

  gle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gle_dp #(
    .SEGMENTS (SEGMENTS),
    .GLYPHS   (GLYPHS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .out_o       (result_o.payload)
  );

endmodule

FILE: src/gle_div.sv
module gle_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gle_pkg::MAG_W-1:0]   dividend_i,
  input  logic [gle_pkg::UPEM_W-1:0]  divisor_i,
  output logic [gle_pkg::MAG_W-1:0]   quot_o,
  output logic                        busy_o
);
  import gle_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  quo_q, quo_d;
  logic [UPEM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic [UPEM_W:0]   shifted;
  logic              ge;

  // one quotient bit a cycle, restoring
  always_comb begin
    shifted = {rem_q, quo_q[MAG_W-1]};
    ge      = shifted >= {1'b0, divisor_i};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(MAG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? UPEM_W'(shifted - {1'b0, divisor_i}) : UPEM_W'(shifted);
      quo_d  = {quo_q[MAG_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quot_o = quo_q;
  assign busy_o = busy_q;

endmodule

FILE: src/gle_ctrl.sv
module gle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gle_pkg::gle_sts_t sts_i,
  output gle_pkg::gle_cmd_t cmd_o
);
  import gle_pkg::*;

  gle_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.in_draw) begin
          cmd_o.draw_go = 1'b1;
          state_d       = ST_SEG_RD;
        end
      end
      ST_SEG_RD: begin
        if (sts_i.seg_end) begin
          state_d = ST_MET_RD;
        end else begin
          cmd_o.seg_rd = 1'b1;
          state_d      = ST_SEG_CMP;
        end
      end
      ST_SEG_CMP: begin
        cmd_o.seg_chk = 1'b1;
        state_d       = sts_i.seg_hit ? ST_MET_RD : ST_SEG_RD;
      end
      ST_MET_RD: begin
        cmd_o.met_rd = 1'b1;
        state_d      = ST_BOX_RD;
      end
      ST_BOX_RD: begin
        cmd_o.box_rd = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_go = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.res_store = 1'b1;
          state_d         = sts_i.last_scale ? ST_FIN : ST_MUL;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: src/gle_dp.sv
module gle_dp #(
  parameter int unsigned SEGMENTS = 64,
  parameter int unsigned GLYPHS   = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gle_pkg::gle_in_t   in_i,
  input  logic               cfg_we_i,
  input  gle_pkg::gle_cfg_t  cfg_i,
  input  gle_pkg::gle_cmd_t  cmd_i,
  output gle_pkg::gle_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output gle_pkg::gle_out_t  out_o
);
  import gle_pkg::*;

  localparam int unsigned SW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned GW = $clog2(GLYPHS);

  // configuration
  logic [SCNT_W-1:0] seg_cnt_q;
  logic [UPEM_W-1:0] upem_q;
  logic [PSZ_W-1:0]  pix_q;
  logic [15:0]       start_x_q, base_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= RST_SEG_CNT;
      upem_q    <= RST_UPEM;
      pix_q     <= RST_PIX_SIZE;
      start_x_q <= RST_START_X;
      base_y_q  <= RST_BASE_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_i.index)
        REG_SEG_CNT:  seg_cnt_q <= cfg_i.data[SCNT_W-1:0];
        REG_UPEM:     upem_q    <= cfg_i.data[UPEM_W-1:0];
        REG_PIX_SIZE: pix_q     <= cfg_i.data[PSZ_W-1:0];
        REG_START_X:  start_x_q <= cfg_i.data;
        REG_BASE_Y:   base_y_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // tables
  gle_seg_t seg_mem [SEGMENTS];
  gle_box_t box_mem [GLYPHS];
  gle_met_t met_mem [GLYPHS];

  logic is_seg_ld, is_gly_ld;
  assign is_seg_ld = cmd_i.accept && (in_i.mode == MODE_LOAD_SEG)
                     && (32'(in_i.slot) < SEGMENTS);
  assign is_gly_ld = cmd_i.accept
                     && ((in_i.mode == MODE_LOAD_GLYPH) || (in_i.mode == MODE_LOAD_EMPTY))
                     && (32'(in_i.slot) < GLYPHS);

  always_ff @(posedge clk_i) begin
    if (is_seg_ld) begin
      seg_mem[SW'(in_i.slot)] <= '{first: in_i.code, last: in_i.code_last,
                                   delta: in_i.code_delta};
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_gly_ld) begin
      box_mem[GW'(in_i.slot)] <= '{xmin: in_i.box_x_min, ymin: in_i.box_y_min,
                                   xmax: in_i.box_x_max, ymax: in_i.box_y_max};
      met_mem[GW'(in_i.slot)] <= '{outlined: in_i.mode == MODE_LOAD_GLYPH,
                                   adv: in_i.advance, lsb: in_i.bearing};
    end
  end

  // segment walk
  logic [SCNT_W-1:0] idx_q, cnt_eff;
  logic [CODE_W-1:0] code_q, glyph_q, gsum;
  gle_seg_t          seg_rd_q;
  logic              hit;

  assign cnt_eff = (32'(seg_cnt_q) > SEGMENTS) ? SCNT_W'(SEGMENTS) : seg_cnt_q;
  assign hit     = (seg_rd_q.first <= code_q) && (code_q <= seg_rd_q.last);
  assign gsum    = code_q + seg_rd_q.delta;

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_rd) begin
      seg_rd_q <= seg_mem[SW'(idx_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.draw_go) begin
      idx_q <= '0;
    end else if (cmd_i.seg_chk && !hit) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw_go) begin
      code_q  <= in_i.code;
      glyph_q <= '0;
    end else if (cmd_i.seg_chk && hit) begin
      glyph_q <= (32'(gsum) < GLYPHS) ? gsum : '0;
    end
  end

  // glyph fetch: metrics first, then the box they select
  gle_met_t met_q;
  gle_box_t box_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.met_rd) begin
      met_q <= met_mem[GW'(glyph_q)];
    end
    if (cmd_i.box_rd) begin
      box_q <= box_mem[met_q.outlined ? GW'(glyph_q) : GW'(0)];
    end
  end

  // scaling: multiply, then serial divide
  logic [KCNT_W-1:0]       k_q;
  logic signed [OP_W-1:0]  op;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PSZ_W:0]   pix_s;
  logic                    neg_q;
  logic [MAG_W-1:0]        mag, quot;
  logic [UPEM_W-1:0]       divisor;
  logic [15:0]             q16;
  logic                    div_busy;
  logic [15:0]             res_q [NSCALE];

  always_comb begin
    unique case (gle_scale_e'(k_q))
      SC_LSB:  op = OP_W'($signed(met_q.lsb));
      SC_XMIN: op = OP_W'($signed(box_q.xmin));
      SC_YMAX: op = OP_W'($signed(box_q.ymax));
      SC_W:    op = OP_W'($signed(box_q.xmax)) - OP_W'($signed(box_q.xmin));
      SC_H:    op = OP_W'($signed(box_q.ymax)) - OP_W'($signed(box_q.ymin));
      SC_ADV:  op = $signed({1'b0, met_q.adv});
      default: op = '0;
    endcase
  end

  assign pix_s   = $signed({1'b0, pix_q});
  assign mag     = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
  assign divisor = (upem_q == '0) ? UPEM_W'(1) : upem_q;
  assign q16     = neg_q ? 16'(-quot[15:0]) : quot[15:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= op * pix_s;
    end
    if (cmd_i.div_go) begin
      neg_q <= prod_q[PROD_W-1];
    end
    if (cmd_i.res_store) begin
      res_q[k_q] <= q16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.draw_go) begin
      k_q <= '0;
    end else if (cmd_i.res_store) begin
      k_q <= k_q + 1'b1;
    end
  end

  gle_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (mag),
    .divisor_i  (divisor),
    .quot_o     (quot),
    .busy_o     (div_busy)
  );

  // cursor and result word
  logic [15:0] cursor_q;
  logic        out_vld_q;
  gle_out_t    out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q  <= RST_START_X;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (in_i.mode == MODE_RESTART)) begin
        cursor_q <= start_x_q;
      end else if (cmd_i.out_load) begin
        cursor_q <= cursor_q + res_q[SC_ADV];
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.rect_x       <= cursor_q + res_q[SC_LSB] + res_q[SC_XMIN];
      out_q.rect_y       <= base_y_q - res_q[SC_YMAX];
      out_q.rect_w       <= res_q[SC_W];
      out_q.rect_h       <= res_q[SC_H];
      out_q.glyph_number <= glyph_q[SLOT_W-1:0];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  assign sts_o.in_draw    = in_i.mode == MODE_DRAW;
  assign sts_o.seg_end    = idx_q == cnt_eff;
  assign sts_o.seg_hit    = hit;
  assign sts_o.last_scale = k_q == SC_ADV;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.out_free   = !out_vld_q || out_ready_i;

endmodule

FILE: verif/tb_glyph_layout_engine_unit.sv
`timescale 1ns / 100ps

module tb_glyph_layout_engine_unit;
  import gle_pkg::*;

  localparam int unsigned SEG_DEPTH   = 64;
  localparam int unsigned GLYPH_DEPTH = 1024;
  localparam int unsigned DRAIN_WAIT  = 400;  // covers the worst draw, a walk of the full segment table
  localparam int unsigned IN_W        = $bits(gle_in_t);
  // mode codes the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic clk_i;
  logic rst_ni;

  gle_in_if  item_bus ();
  gle_out_if rect_bus ();
  gle_cfg_if cfg_bus ();

  glyph_layout_engine_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (rect_bus),
    .cfg_i    (cfg_bus)
  );

  // Shadow copy of the block's tables, registers and cursor
  gle_seg_t          seg_tab   [SEG_DEPTH];
  gle_box_t          box_tab   [GLYPH_DEPTH];
  gle_met_t          met_tab   [GLYPH_DEPTH];
  bit                glyph_ok  [GLYPH_DEPTH];
  logic [SCNT_W-1:0] seg_cnt_q;
  logic [UPEM_W-1:0] upem_q;
  logic [PSZ_W-1:0]  psize_q;
  logic [15:0]       start_x_q;
  logic [15:0]       base_y_q;
  logic [15:0]       cursor_q;

  gle_out_t pending_rects[$];

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned hold_cycles;
  int unsigned n_errors;
  int unsigned n_rects;
  int unsigned n_words;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Generous limit covering every draw, heavy stalls and the long hold-off
  initial begin
    #20ms;
    $display("[glyph_layout_engine_unit] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d (rect %0d)", what, got, want, n_rects);
    n_errors++;
  endtask

  // v * size / upem, truncated toward zero; a zero divisor counts as one
  function automatic longint scaled(input longint v);
    longint d;
    d = (upem_q == 0) ? 1 : longint'(upem_q);
    return v * longint'(psize_q) / d;
  endfunction

  // First segment in range wins; no hit or an index past the table gives glyph 0
  function automatic int unsigned map_glyph(input logic [15:0] ch);
    int unsigned lim;
    int unsigned g;
    lim = (seg_cnt_q < SEG_DEPTH) ? seg_cnt_q : SEG_DEPTH;
    g = 0;
    for (int unsigned i = 0; i < lim; i++) begin
      if (seg_tab[i].first <= ch && ch <= seg_tab[i].last) begin
        g = 16'(ch + seg_tab[i].delta);
        break;
      end
    end
    return (g >= GLYPH_DEPTH) ? 0 : g;
  endfunction

  task automatic predict_word(input gle_in_t w);
    int unsigned g;
    gle_box_t    b;
    gle_met_t    m;
    gle_out_t    r;
    longint      xmin, ymin, xmax, ymax;
    case (w.mode)
      MODE_LOAD_SEG: begin
        if (w.slot < SEG_DEPTH) seg_tab[w.slot] = '{w.code, w.code_last, w.code_delta};
      end
      MODE_LOAD_GLYPH, MODE_LOAD_EMPTY: begin
        box_tab[w.slot] = '{w.box_x_min, w.box_y_min, w.box_x_max, w.box_y_max};
        met_tab[w.slot] = '{w.mode == MODE_LOAD_GLYPH, w.advance, w.bearing};
        glyph_ok[w.slot] = 1'b1;
      end
      MODE_RESTART: cursor_q = start_x_q;
      MODE_DRAW: begin
        g = map_glyph(w.code);
        m = met_tab[g];
        b = m.outlined ? box_tab[g] : box_tab[0];  // empty glyphs borrow glyph 0's box
        xmin = longint'($signed(b.xmin));
        ymin = longint'($signed(b.ymin));
        xmax = longint'($signed(b.xmax));
        ymax = longint'($signed(b.ymax));
        r.rect_x = 16'(longint'($signed(cursor_q)) + scaled(longint'($signed(m.lsb)))
                   + scaled(xmin));
        r.rect_y = 16'(longint'($signed(base_y_q)) - scaled(ymax));
        r.rect_w = 16'(scaled(xmax - xmin));
        r.rect_h = 16'(scaled(ymax - ymin));
        r.glyph_number = SLOT_W'(g);
        pending_rects.push_back(r);
        cursor_q = 16'(longint'($signed(cursor_q)) + scaled(longint'(m.adv)));
      end
      default: ;  // spare modes do nothing
    endcase
  endtask

  // Offer one word, idling first at the current sender rate
  task automatic send_word(input gle_in_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_bus.valid   <= 1'b1;
    item_bus.payload <= w;
    do @(posedge clk_i); while (!item_bus.ready);
    predict_word(w);
    n_words++;
  endtask

  task automatic stop_sending();
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    stop_sending();
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input gle_reg_e idx, input logic [15:0] val);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.payload <= '{idx, val};
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_SEG_CNT:  seg_cnt_q = val[SCNT_W-1:0];
      REG_UPEM:     upem_q    = val[UPEM_W-1:0];
      REG_PIX_SIZE: psize_q   = val[PSZ_W-1:0];
      REG_START_X:  start_x_q = val;
      default:      base_y_q  = val;
    endcase
    @(posedge clk_i);
  endtask

  function automatic gle_in_t rand_word();
    gle_in_t w;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  // Mostly a short range that lands on a real glyph; some noise and inverted ranges
  task automatic load_segment(input int unsigned slot);
    gle_in_t w;
    int unsigned pick;
    w = rand_word();
    pick = $urandom_range(99);
    w.mode = MODE_LOAD_SEG;
    w.slot = SLOT_W'(slot);
    if (pick < 85) begin
      w.code_last  = (w.code > 16'hFFEB) ? 16'hFFFF : w.code + 16'($urandom_range(20));
      w.code_delta = 16'($urandom_range(GLYPH_DEPTH - 1)) - w.code;
    end else if (pick < 92) begin
      w.code_last = w.code - 16'($urandom_range(1, 5));  // empty range
    end
    send_word(w);
  endtask

  task automatic load_glyph(input int unsigned slot);
    gle_in_t w;
    w = rand_word();
    w.mode = ($urandom_range(3) == 0) ? MODE_LOAD_EMPTY : MODE_LOAD_GLYPH;
    w.slot = SLOT_W'(slot);
    send_word(w);
  endtask

  // Draws never touch a glyph that was never loaded
  task automatic draw_code(input logic [15:0] ch);
    gle_in_t     w;
    int unsigned g;
    g = map_glyph(ch);
    if (!glyph_ok[g]) load_glyph(g);
    w = rand_word();
    w.mode = MODE_DRAW;
    w.code = ch;
    send_word(w);
  endtask

  function automatic logic [15:0] pick_char();
    int unsigned s;
    if ($urandom_range(9) < 8) begin
      s = $urandom_range(SEG_DEPTH - 1);
      if (seg_tab[s].first <= seg_tab[s].last)
        return 16'($urandom_range(seg_tab[s].first, seg_tab[s].last));
    end
    return 16'($urandom);
  endfunction

  task automatic random_words(input int unsigned n);
    gle_in_t w;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) draw_code(pick_char());
      else if (pick < 72) load_segment($urandom_range(SEG_DEPTH - 1));
      else if (pick < 86) load_glyph($urandom_range(GLYPH_DEPTH - 1));
      else if (pick < 93) begin
        w = rand_word();
        w.mode = MODE_RESTART;
        send_word(w);
      end else begin
        w = rand_word();
        w.mode = gle_mode_e'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        send_word(w);
      end
    end
  endtask

  // Result side: random ready, or a counted hold-off when one is requested
  initial begin
    rect_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rect_bus.valid && rect_bus.ready) begin
        if (pending_rects.size() == 0) begin
          report_mismatch("rect word with nothing outstanding", 1, 0);
        end else begin
          gle_out_t want;
          want = pending_rects.pop_front();
          if (rect_bus.payload.rect_x != want.rect_x)
            report_mismatch("rect_x", rect_bus.payload.rect_x, want.rect_x);
          if (rect_bus.payload.rect_y != want.rect_y)
            report_mismatch("rect_y", rect_bus.payload.rect_y, want.rect_y);
          if (rect_bus.payload.rect_w != want.rect_w)
            report_mismatch("rect_w", rect_bus.payload.rect_w, want.rect_w);
          if (rect_bus.payload.rect_h != want.rect_h)
            report_mismatch("rect_h", rect_bus.payload.rect_h, want.rect_h);
          if (rect_bus.payload.glyph_number != want.glyph_number)
            report_mismatch("glyph_number", rect_bus.payload.glyph_number,
                            want.glyph_number);
          n_rects++;
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        rect_bus.ready <= 1'b0;
      end else begin
        rect_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Fill every segment and glyph 0 so no draw can reach an unwritten entry
  task automatic test_table_fill();
    load_glyph(0);
    for (int unsigned i = 0; i < SEG_DEPTH; i++) load_segment(i);
    wait_idle();
    write_reg(REG_SEG_CNT, 16'd64);
  endtask

  task automatic test_directed();
    gle_in_t w;
    // segment at slot 0 holding only code 0, delta pushing past the table
    w = rand_word();
    w.mode = MODE_LOAD_SEG; w.slot = 0;
    w.code = 16'h0000; w.code_last = 16'h0000; w.code_delta = 16'hFFFF;  // 0 -> 65535
    send_word(w);
    w.slot = 1; w.code = 16'hFFFF; w.code_last = 16'hFFFF; w.code_delta = 16'h0005;  // wraps
    send_word(w);
    w.slot = 2; w.code = 16'h0100; w.code_last = 16'h0104; w.code_delta = 16'hFF00;
    send_word(w);
    // loads to slots past the segment table are dropped
    w.slot = 10'd64;  w.code = 16'h0000; w.code_last = 16'hFFFF;
    send_word(w);
    w.slot = 10'd1023;
    send_word(w);
    // extreme boxes, empty glyph, top glyph slot
    w = rand_word();
    w.mode = MODE_LOAD_GLYPH; w.slot = 0;
    w.box_x_min = 16'sh8000; w.box_y_min = 16'sh8000;
    w.box_x_max = 16'sh7FFF; w.box_y_max = 16'sh7FFF;
    w.advance = 16'hFFFF; w.bearing = 16'sh8000;
    send_word(w);
    w.mode = MODE_LOAD_EMPTY; w.slot = 10'd4;
    w.box_x_min = 16'sh7FFF; w.box_x_max = 16'sh8000; w.bearing = 16'sh7FFF;
    send_word(w);
    w.mode = MODE_LOAD_GLYPH; w.slot = 10'd1023; w.advance = 16'h0000;
    send_word(w);
    draw_code(16'h0000);  // index past the table
    draw_code(16'hFFFF);  // delta wraps to 4, empty glyph
    draw_code(16'h0103);  // 0x0003
    draw_code(16'h0104);
    draw_code(16'h00FF);  // matched later in the table, or glyph 0
    w.mode = MODE_RESTART;
    send_word(w);
    draw_code(16'h0100);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
      w = rand_word();
      w.mode = gle_mode_e'(m);
      send_word(w);
    end
    draw_code(16'h0102);
    wait_idle();
  endtask

  // Registers at their extremes, including a zero divisor, zero size and
  // a segment count beyond the table
  task automatic test_register_extremes();
    write_reg(REG_UPEM, 16'd16);
    write_reg(REG_PIX_SIZE, 16'd1024);
    write_reg(REG_START_X, 16'h7FFF);
    write_reg(REG_BASE_Y, 16'h8000);
    random_words(10);
    wait_idle();
    write_reg(REG_UPEM, 16'h0000);
    write_reg(REG_PIX_SIZE, 16'hFFFF);
    write_reg(REG_SEG_CNT, 16'hFFFF);
    write_reg(REG_START_X, 16'h8000);
    write_reg(REG_BASE_Y, 16'h7FFF);
    random_words(10);
    wait_idle();
    write_reg(REG_PIX_SIZE, 16'd0);
    write_reg(REG_UPEM, 16'd16384);
    write_reg(REG_SEG_CNT, 16'd0);
    random_words(8);
    wait_idle();
    write_reg(REG_PIX_SIZE, 16'd1);
    write_reg(REG_UPEM, 16'h7FFF);
    write_reg(REG_SEG_CNT, 16'd1);
    random_words(8);
    wait_idle();
  endtask

  // Result side held off so the output register fills and the input stalls;
  // then the sender waits for everything to come back before going on
  task automatic test_backpressure();
    write_reg(REG_UPEM, 16'd2048);
    write_reg(REG_PIX_SIZE, 16'd64);
    write_reg(REG_SEG_CNT, 16'd64);
    hold_cycles = 3000;
    repeat (6) draw_code(pick_char());
    stop_sending();
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (4) draw_code(pick_char());
    wait_idle();
  endtask

  task automatic test_random_phases();
    src_idle_pct = 34; snk_idle_pct = 58;
    random_words(60);
    wait_idle();
    write_reg(REG_UPEM, 16'($urandom_range(16, 16384)));
    write_reg(REG_PIX_SIZE, 16'($urandom_range(1, 1024)));
    write_reg(REG_START_X, 16'($urandom));
    write_reg(REG_BASE_Y, 16'($urandom));
    write_reg(REG_SEG_CNT, 16'($urandom_range(20, 64)));
    src_idle_pct = 58; snk_idle_pct = 34;
    random_words(60);
    wait_idle();
    write_reg(REG_UPEM, 16'd1000);
    write_reg(REG_PIX_SIZE, 16'd12);
    write_reg(REG_SEG_CNT, 16'd64);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_words(60);
  endtask

  initial begin
    rst_ni           = 1'b0;
    item_bus.valid   = 1'b0;
    item_bus.payload = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.payload  = '0;
    src_idle_pct = 0; snk_idle_pct = 0; hold_cycles = 0;
    n_errors = 0; n_rects = 0; n_words = 0;
    seg_cnt_q = RST_SEG_CNT; upem_q = RST_UPEM; psize_q = RST_PIX_SIZE;
    start_x_q = RST_START_X; base_y_q = RST_BASE_Y; cursor_q = RST_START_X;
    foreach (glyph_ok[i]) glyph_ok[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_fill();
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    wait_idle();

    $display("%0d words sent, %0d rectangles checked across register extremes,",
             n_words, n_rects);
    $display("wrapped and missing mappings, empty glyphs and output back-pressure");
    if (n_errors == 0) begin
      $display("[glyph_layout_engine_unit] OK");
    end else begin
      $display("[glyph_layout_engine_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gle_pkg.sv
src/gle_if.sv
src/gle_div.sv
src/gle_ctrl.sv
src/gle_dp.sv
src/glyph_layout_engine_unit.sv
verif/tb_glyph_layout_engine_unit.sv
